// ===== rtl/fqz_pkg.sv =====
// Shared types, command codes and FP16 helpers for the FP16 to int8 quantizer.
`timescale 1ns / 1ps
package fqz_pkg;

  // Input beat: one tensor element.
  typedef struct packed {
    logic        opcode;
    logic [15:0] sample;
    logic        last;
  } in_item_t;

  // Result beat: scale report or quantized element.
  typedef struct packed {
    logic              kind;
    logic signed [7:0] code;
    logic [15:0]       scale_bits;
    logic              end_flag;
  } out_item_t;

  // Opcodes and result kinds
  localparam logic OP_SCAN     = 1'b0;
  localparam logic OP_QUANT    = 1'b1;
  localparam logic KIND_SCALE  = 1'b0;
  localparam logic KIND_ELEM   = 1'b1;

  // Classified commands passed from the front to the back
  localparam logic [1:0] CMD_SCAN     = 2'd0;
  localparam logic [1:0] CMD_SCAN_END = 2'd1;
  localparam logic [1:0] CMD_QUANT    = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        last;
    logic        is_nan;
    logic [15:0] sample;
  } cmd_item_t;

  // FP16 constants
  localparam logic [15:0] FP16_ONE    = 16'h3C00;
  localparam logic [15:0] FP16_MAXFIN = 16'h7BFF;
  localparam logic [14:0] FP16_INF    = 15'h7C00;

  // Queue depth on both sides
  localparam int unsigned QDEPTH = 2;

  // Map FP16 bits to an unsigned key that orders like the numeric value.
  function automatic logic [15:0] fp16_key(input logic [15:0] h);
    fp16_key = h[15] ? ~h : {1'b1, h[14:0]};
  endfunction

  function automatic logic fp16_is_nan(input logic [15:0] h);
    fp16_is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
  endfunction

endpackage

// ===== rtl/fqz_front.sv =====
// Front end: input queue that accepts element beats and classifies them.
`timescale 1ns / 1ps
module fqz_front import fqz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      q_valid,
  output cmd_item_t q_cmd,
  input  logic      q_pop
);

  cmd_item_t  mem_r [QDEPTH];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  cmd_item_t  cls;

  assign in_full = (cnt_r == 2'(QDEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rptr_r];
  assign push    = in_push && !in_full;
  assign pop     = q_pop && q_valid;

  // Classify the incoming beat
  always_comb begin
    cls.sample = in_item.sample;
    cls.last   = in_item.last;
    cls.is_nan = fp16_is_nan(in_item.sample);
    if (in_item.opcode == OP_QUANT) begin
      cls.cmd = CMD_QUANT;
    end else if (in_item.last) begin
      cls.cmd = CMD_SCAN_END;
    end else begin
      cls.cmd = CMD_SCAN;
    end
  end

  // Store classified beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cls;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/fqz_back.sv =====
// Back end: range tracking, iterative scale division, quantize and result queue.
`timescale 1ns / 1ps
module fqz_back import fqz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_item_t   q_cmd,
  output logic        q_pop,
  input  logic        cfg_valid,
  input  logic [14:0] cfg_data,
  input  logic        out_pop,
  output logic        out_empty,
  output out_item_t   out_result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [38:0] DIVIDEND = 39'd127 << 32;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] max_r, max_nxt, min_r, min_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] scale_r, scale_nxt;
  logic [14:0] floor_r;
  logic [11:0] rem_r, rem_nxt;
  logic [28:0] quo_r, quo_nxt;
  logic [10:0] mn_r, mn_nxt;
  logic signed [6:0] x_r, x_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  out_item_t  omem_r [QDEPTH];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       opush, opop, ospace;
  out_item_t  opush_item;

  // Range update for the head beat
  logic [15:0] umax, umin;
  logic        useen;
  always_comb begin
    umax  = max_r;
    umin  = min_r;
    useen = seen_r;
    if (!q_cmd.is_nan) begin
      if (!seen_r) begin
        umax  = q_cmd.sample;
        umin  = q_cmd.sample;
        useen = 1'b1;
      end else begin
        if (fp16_key(q_cmd.sample) > fp16_key(max_r)) umax = q_cmd.sample;
        if (fp16_key(q_cmd.sample) < fp16_key(min_r)) umin = q_cmd.sample;
      end
    end
  end

  // Largest magnitude and divisor setup
  logic [14:0] mag;
  logic [10:0] mn_ld;
  logic signed [6:0] x_ld;
  logic [3:0]  lz;
  always_comb begin
    mag = (umax[14:0] > umin[14:0]) ? umax[14:0] : umin[14:0];
    lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mag[i]) lz = 4'(10 - i);
    end
    if (mag[14:10] != 5'd0) begin
      mn_ld = {1'b1, mag[9:0]};
      x_ld  = $signed({2'b00, mag[14:10]}) - 7'sd25;
    end else begin
      mn_ld = {1'b0, mag[9:0]} << lz;
      x_ld  = -7'sd24 - $signed({3'b000, lz});
    end
  end

  logic [14:0] floor_cl;
  assign floor_cl = (floor_r > FP16_MAXFIN[14:0]) ? FP16_MAXFIN[14:0] : floor_r;

  // Divider step: one quotient bit per cycle
  logic [11:0] rem_sh;
  logic        q_ge;
  assign rem_sh = {rem_r[10:0], DIVIDEND[cnt_r]};
  assign q_ge   = (rem_sh >= {1'b0, mn_r});

  // Round the quotient to single precision, then to FP16
  logic        p28, rinc, hinc;
  logic [23:0] keep24;
  logic [24:0] m25;
  logic [22:0] frac23;
  logic signed [7:0] fexp, hexp;
  logic [15:0] raw, rnd, fin_scale;
  always_comb begin
    p28    = quo_r[28];
    fexp   = (p28 ? -8'sd4 : -8'sd5) - 8'(x_r);
    keep24 = p28 ? quo_r[28:5] : quo_r[27:4];
    rinc   = (p28 ? quo_r[4] : quo_r[3]) &&
             ((p28 ? (quo_r[3:0] != 4'd0) : (quo_r[2:0] != 3'd0)) ||
              (rem_r != 12'd0) || keep24[0]);
    m25    = {1'b0, keep24} + {24'd0, rinc};
    if (m25[24]) begin
      frac23 = 23'd0;
      fexp   = fexp + 8'sd1;
    end else begin
      frac23 = m25[22:0];
    end
    hexp = fexp + 8'sd15;
    hinc = (frac23[12:0] > 13'h1000) || ((frac23[12:0] == 13'h1000) && frac23[13]);
    rnd  = {1'b0, hexp[4:0], frac23[22:13]} + {15'd0, hinc};
    if (hexp >= 8'sd31 || rnd > FP16_MAXFIN) begin
      raw = FP16_MAXFIN;
    end else begin
      raw = rnd;
    end
    fin_scale = (raw > {1'b0, floor_cl}) ? raw : {1'b0, floor_cl};
  end

  // Quantize the head beat with the current scale
  logic [10:0] ms, mc;
  logic signed [6:0] xs, xc, xsum;
  logic [21:0] prod;
  logic [31:0] qval;
  logic [5:0]  rsh;
  logic [6:0]  qmag;
  logic signed [7:0] qcode;
  always_comb begin
    ms   = {(q_cmd.sample[14:10] != 5'd0), q_cmd.sample[9:0]};
    mc   = {(scale_r[14:10] != 5'd0), scale_r[9:0]};
    xs   = $signed({2'b00, (q_cmd.sample[14:10] == 5'd0) ? 5'd1 : q_cmd.sample[14:10]})
           - 7'sd25;
    xc   = $signed({2'b00, (scale_r[14:10] == 5'd0) ? 5'd1 : scale_r[14:10]}) - 7'sd25;
    xsum = xs + xc;
    prod = ms * mc;
    rsh  = 6'(-xsum);
    if (xsum >= 7'sd0) begin
      qval = {10'd0, prod} << xsum[3:0];
    end else if (rsh >= 6'd22) begin
      qval = 32'd0;
    end else begin
      qval = {10'd0, prod >> rsh};
    end
    qmag = (qval >= 32'd127) ? 7'd127 : qval[6:0];
    if (q_cmd.sample[14:10] == 5'h1F) begin
      if (q_cmd.is_nan || scale_r[14:0] == 15'd0) qmag = 7'd0;
      else qmag = 7'd127;
    end
    qcode = q_cmd.sample[15] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  assign ospace = (ocnt_r != 2'(QDEPTH));

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    max_nxt    = max_r;
    min_nxt    = min_r;
    seen_nxt   = seen_r;
    scale_nxt  = scale_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    mn_nxt     = mn_r;
    x_nxt      = x_r;
    cnt_nxt    = cnt_r;
    q_pop      = 1'b0;
    opush      = 1'b0;
    opush_item = '{kind: KIND_SCALE, code: 8'sd0, scale_bits: scale_r, end_flag: 1'b1};
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.cmd)
            CMD_SCAN: begin
              q_pop   = 1'b1;
              max_nxt = umax;
              min_nxt = umin;
              seen_nxt = useen;
            end
            CMD_QUANT: begin
              if (ospace) begin
                q_pop      = 1'b1;
                opush      = 1'b1;
                opush_item = '{kind: KIND_ELEM, code: qcode, scale_bits: scale_r,
                               end_flag: q_cmd.last};
              end
            end
            CMD_SCAN_END: begin
              if (!useen || mag == 15'd0 || mag == FP16_INF) begin
                if (ospace) begin
                  q_pop     = 1'b1;
                  opush     = 1'b1;
                  scale_nxt = (mag == FP16_INF && useen) ? {1'b0, floor_cl} : FP16_ONE;
                  opush_item.scale_bits = scale_nxt;
                  max_nxt   = 16'd0;
                  min_nxt   = 16'd0;
                  seen_nxt  = 1'b0;
                end
              end else begin
                q_pop     = 1'b1;
                max_nxt   = 16'd0;
                min_nxt   = 16'd0;
                seen_nxt  = 1'b0;
                rem_nxt   = 12'd0;
                quo_nxt   = 29'd0;
                mn_nxt    = mn_ld;
                x_nxt     = x_ld;
                cnt_nxt   = 6'd38;
                state_nxt = ST_DIV;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt = q_ge ? (rem_sh - {1'b0, mn_r}) : rem_sh;
        quo_nxt = {quo_r[27:0], q_ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (ospace) begin
          opush      = 1'b1;
          scale_nxt  = fin_scale;
          opush_item.scale_bits = fin_scale;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      max_r   <= 16'd0;
      min_r   <= 16'd0;
      seen_r  <= 1'b0;
      scale_r <= FP16_ONE;
      floor_r <= 15'd0;
    end else begin
      state_r <= state_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      seen_r  <= seen_nxt;
      scale_r <= scale_nxt;
      if (cfg_valid) floor_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    mn_r  <= mn_nxt;
    x_r   <= x_nxt;
    cnt_r <= cnt_nxt;
  end

  // Result queue
  assign out_empty  = (ocnt_r == 2'd0);
  assign out_result = omem_r[orp_r];
  assign opop       = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (opush) omem_r[owp_r] <= opush_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (opush) owp_r <= ~owp_r;
      if (opop)  orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, opush} - {1'b0, opop};
    end
  end

endmodule

// ===== rtl/fp16_to_int8_symmetric_quantizer_top.sv =====
// Top level of the FP16 to int8 symmetric quantizer.
//
// Input channel: push an element beat (opcode, sample, last) while in_full is low.
// A tensor is fed twice: scan beats (opcode 0) build the value range, quantize
// beats (opcode 1) are scaled to int8 codes with the current scale.
// Result channel: a result waits on out_result while out_empty is low and
// leaves on out_pop. A scan beat without last gives no result; the last scan
// beat gives one scale report; every quantize beat gives one code.
// Config: cfg_data is the floor scale, taken on cfg_valid (cfg_ready is always
// high); write it only while the block is idle.
// Streaming: scan beats pass through the back end at one beat per cycle while no
// scale division is running, and quantize beats do so while the result queue has room;
// a result is registered in the result queue and waits on out_result until popped.
// At the end of a scan over a nonzero, finite range the scale division retires one
// quotient bit per cycle over 39 steps, then ST_FIN rounds and pushes the report.
// Reset clears the range, sets the scale to 1.0 and the floor to zero; both
// queues come out empty. When the receiver stalls, the two-entry result queue
// fills, the back end holds, and in_full rises once the input queue fills.
`timescale 1ns / 1ps
module fp16_to_int8_symmetric_quantizer_top import fqz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  input  logic        out_pop,
  output logic        out_empty,
  output out_item_t   out_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  logic      q_valid, q_pop;
  cmd_item_t q_cmd;

  assign cfg_ready = 1'b1;

  fqz_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  fqz_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_result (out_result)
  );

endmodule

// ===== rtl/fqz_checker.sv =====
// Port-level checker for the quantizer top level, with its bind.
`timescale 1ns / 1ps
module fqz_port_checker import fqz_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_pop,
  input logic      out_empty,
  input out_item_t out_result
);

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A scale report carries code zero and the end flag
  a_report_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result.kind == KIND_SCALE) |->
      (out_result.code == 8'sd0 && out_result.end_flag))
    else $error("malformed scale report");

  // Codes stay within plus or minus 127
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_result.code != -8'sd128)
    else $error("code out of range");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result)))
    else $error("stalled result changed");

endmodule

bind fp16_to_int8_symmetric_quantizer_top fqz_port_checker u_fqz_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_full    (in_full),
  .out_pop    (out_pop),
  .out_empty  (out_empty),
  .out_result (out_result)
);
